// ----- src/arp_pkg.sv -----
// Shared types and constants of the ARP cache and responder.
package arp_pkg;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned OP_W    = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_W   = 48;
  // table entry: {pending, ip, mac}
  localparam int unsigned ENTRY_W = 1 + IP_W + MAC_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT      = 3'd0,
    KIND_MISS     = 3'd1,
    KIND_PENDING  = 3'd2,
    KIND_REPLY    = 3'd3,
    KIND_RESOLVED = 3'd4,
    KIND_ADDED    = 3'd5,
    KIND_FULL     = 3'd6,
    KIND_IGNORED  = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam logic            REQ_LOOKUP    = 1'b0;
  localparam logic [OP_W-1:0] OP_ARP_REQUEST = 16'd1;
  localparam logic [OP_W-1:0] OP_ARP_REPLY   = 16'd2;

  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

endpackage

// ----- src/arp_cache_and_responder.sv -----
// ARP cache and responder: IPv4-to-MAC table with lookup and ARP packet handling.
//
// Input channel (in_valid_i / in_stall_o) carries either a lookup from the IP
// layer (req_type 0) or the fields of a received ARP packet (req_type 1).
// Each input transfer yields exactly one result transfer on the output channel
// (out_valid_o / out_stall_i): hit, miss with broadcast request, pending,
// reply to send, resolved, added, table full, or ignored.
// The table lives in one synchronous memory; valid entries always fill from
// slot 0 upwards, so a fill count replaces per-entry valid bits.
// Lookups and ARP replies scan the filled entries one read per cycle and stop
// at the first hit; ARP requests and unknown opcodes skip the scan.
// One item is handled at a time; in_stall_o is low only while idle. The
// output register lets a new item be taken while a result still waits.
// If the receiver stalls, the finished result of the next item is held until
// the output register drains, and the table write happens at that point.
// Reset empties the table and clears own_ip. own_mac writes are accepted but
// have no effect on any result. Configuration is written with cfg_we_i.
module arp_cache_and_responder #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [arp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [arp_pkg::IP_W-1:0]  query_ip_i,
  input  logic [arp_pkg::OP_W-1:0]  arp_opcode_i,
  input  logic [arp_pkg::IP_W-1:0]  sender_ip_i,
  input  logic [arp_pkg::MAC_W-1:0] sender_mac_i,
  input  logic [arp_pkg::IP_W-1:0]  target_ip_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [arp_pkg::KIND_W-1:0] result_kind_o,
  output logic [arp_pkg::IP_W-1:0]  result_ip_o,
  output logic [arp_pkg::MAC_W-1:0] result_mac_o
);
  import arp_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic [IP_W-1:0]     own_ip_q;

  logic                is_lookup_q, is_lookup_d;
  logic [IP_W-1:0]     key_q, key_d;
  logic [MAC_W-1:0]    mac_q, mac_d;

  kind_e               res_kind_q, res_kind_d;
  logic [IP_W-1:0]     res_ip_q, res_ip_d;
  logic [MAC_W-1:0]    res_mac_q, res_mac_d;
  logic                wr_en_q, wr_en_d;
  logic                fill_inc_q, fill_inc_d;
  logic [IDX_W-1:0]    wr_addr_q, wr_addr_d;
  logic [ENTRY_W-1:0]  wr_data_q, wr_data_d;

  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [IP_W-1:0]     out_ip_q;
  logic [MAC_W-1:0]    out_mac_q;

  logic [ENTRY_W-1:0]  mem_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]  rd_data_q;

  logic in_fire, emit_fire, hit, more;
  logic                rd_pending;
  logic [IP_W-1:0]     rd_ip;
  logic [MAC_W-1:0]    rd_mac;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_fire       = in_valid_i && (state_q == ST_IDLE);
  assign emit_fire     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign rd_pending = rd_data_q[ENTRY_W-1];
  assign rd_ip      = rd_data_q[MAC_W +: IP_W];
  assign rd_mac     = rd_data_q[MAC_W-1:0];
  assign hit        = cmp_vld_q && (rd_ip == key_q);
  assign more       = (rd_idx_q != fill_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    is_lookup_d = is_lookup_q;
    key_d       = key_q;
    mac_d       = mac_q;
    res_kind_d  = res_kind_q;
    res_ip_d    = res_ip_q;
    res_mac_d   = res_mac_q;
    wr_en_d     = wr_en_q;
    fill_inc_d  = fill_inc_q;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          is_lookup_d = (req_type_i == REQ_LOOKUP);
          key_d       = (req_type_i == REQ_LOOKUP) ? query_ip_i : sender_ip_i;
          mac_d       = sender_mac_i;
          wr_en_d     = 1'b0;
          fill_inc_d  = 1'b0;
          rd_idx_d    = '0;
          if (req_type_i == REQ_LOOKUP || arp_opcode_i == OP_ARP_REPLY) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
            if (arp_opcode_i == OP_ARP_REQUEST && target_ip_i == own_ip_q) begin
              res_kind_d = KIND_REPLY;
              res_ip_d   = sender_ip_i;
              res_mac_d  = sender_mac_i;
            end else begin
              res_kind_d = KIND_IGNORED;
              res_ip_d   = '0;
              res_mac_d  = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, compare on the data read the cycle before
        cmp_vld_d = more;
        rd_idx_d  = rd_idx_q + CNT_W'(more);
        res_ip_d  = key_q;
        if (hit) begin
          state_d = ST_EMIT;
          if (is_lookup_q) begin
            res_kind_d = rd_pending ? KIND_PENDING : KIND_HIT;
            res_mac_d  = rd_pending ? '0 : rd_mac;
          end else begin
            res_kind_d = KIND_RESOLVED;
            res_mac_d  = mac_q;
            wr_en_d    = 1'b1;
            wr_addr_d  = cmp_idx_q;
            wr_data_d  = {1'b0, key_q, mac_q};
          end
        end else if (!more) begin
          state_d   = ST_EMIT;
          wr_addr_d = fill_q[IDX_W-1:0];
          if (fill_q == FULL_CNT) begin
            res_kind_d = KIND_FULL;
            res_mac_d  = '0;
          end else if (is_lookup_q) begin
            res_kind_d = KIND_MISS;
            res_mac_d  = '0;
            wr_en_d    = 1'b1;
            fill_inc_d = 1'b1;
            wr_data_d  = {1'b1, key_q, {MAC_W{1'b0}}};
          end else begin
            res_kind_d = KIND_ADDED;
            res_mac_d  = mac_q;
            wr_en_d    = 1'b1;
            fill_inc_d = 1'b1;
            wr_data_d  = {1'b0, key_q, mac_q};
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
          fill_d  = fill_q + CNT_W'(fill_inc_q);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      own_ip_q    <= '0;
      out_valid_q <= 1'b0;
      wr_en_q     <= 1'b0;
      fill_inc_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      wr_en_q     <= wr_en_d;
      fill_inc_q  <= fill_inc_d;
      out_valid_q <= emit_fire || (out_valid_q && out_stall_i);
      // own_mac only sources outgoing frames, which are built elsewhere
      if (cfg_we_i && cfg_idx_i == CFG_OWN_IP) begin
        own_ip_q <= cfg_wdata_i[IP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= rd_idx_q[IDX_W-1:0];
    is_lookup_q <= is_lookup_d;
    key_q       <= key_d;
    mac_q       <= mac_d;
    res_kind_q  <= res_kind_d;
    res_ip_q    <= res_ip_d;
    res_mac_q   <= res_mac_d;
    wr_addr_q   <= wr_addr_d;
    wr_data_q   <= wr_data_d;
    if (emit_fire) begin
      out_kind_q <= res_kind_q;
      out_ip_q   <= res_ip_q;
      out_mac_q  <= res_mac_q;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (emit_fire && wr_en_q) begin
      mem_q[wr_addr_q] <= wr_data_q;
    end
    rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign result_ip_o   = out_ip_q;
  assign result_mac_o  = out_mac_q;

endmodule
